// ===== design/plate_ball_filter_pid_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the plate ball filter PID block.
// Concurrent checks clocked on the block clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PLATE_BALL_FILTER_PID_ASSERT_SVH
`define PLATE_BALL_FILTER_PID_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plate ball filter pid: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plate ball filter pid: next-cycle check failed");

`endif

// ===== design/pbf_pkg.sv =====
// ----------------------------------------------------------------------------
// pbf_pkg
// Shared types and fixed constants of the plate ball filter PID block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbf_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_CUTOFF = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP   = 3'd7;

    // Register widths and reset values.
    localparam int GAIN_W  = 24;
    localparam int LOSS_W  = 8;
    localparam int STEP_W  = 8;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = 24'd32768;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 24'd655;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 24'd14417920;
    localparam logic [LOSS_W-1:0] LOSS_CUTOFF_RST = 8'd30;
    localparam logic [STEP_W-1:0] MAX_STEP_RST    = 8'd4;

    // Arithmetic formats.
    localparam int GAIN_FRAC     = 16;
    localparam int INTEG_W       = 32;
    localparam int ITERM_LIM_EXP = 40;
    localparam int SPIKE_W       = 10;
    localparam int TILT_W        = 11;
    localparam int PID_W         = 13;
    localparam int PHASE_W       = 3;

    // Ball loss window on the raw samples.
    localparam int LOSS_X_LOW  = -120;
    localparam int LOSS_Y_HIGH = 100;

    // Per-axis control derived from the loss and presence decision.
    typedef struct packed {
        logic step;     // item accepted, state may change
        logic zero;     // ball declared lost: clear coordinate and integral
        logic acquire;  // ball found again: jump to the raw sample
        logic filter;   // ball present and sample good: spike filter
        logic track;    // ball present after this item: run PID update
        logic vel_upd;  // velocity update tick
    } t_axis_ctl;

endpackage

`default_nettype wire

// ===== design/pbf_axis.sv =====
// ----------------------------------------------------------------------------
// pbf_axis
// Per-axis position filter and PID state update: spike filter, offset,
// integral and decimated velocity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbf_axis
    import pbf_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8,
    parameter int VEL_PERIOD  = 3
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire  t_axis_ctl                        i_ctl,
    input  wire  [SAMPLE_BITS-1:0]                 i_raw,
    input  wire  [SAMPLE_BITS-1:0]                 i_target,
    input  wire  [STEP_W-1:0]                      i_max_step,
    output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] o_coord,
    output logic signed [SAMPLE_BITS+FRAC_BITS:0]   o_offset,
    output logic signed [SAMPLE_BITS+FRAC_BITS+1:0] o_velocity,
    output logic signed [INTEG_W-1:0]               o_integral
);

    localparam int CW   = SAMPLE_BITS + FRAC_BITS;
    localparam int OW   = CW + 1;
    localparam int VW   = CW + 2;
    localparam int VS   = VW + 3;
    localparam int MW   = SAMPLE_BITS + 1;
    localparam int LW   = STEP_W + SPIKE_W;
    localparam int CMPW = (MW > LW) ? MW : LW;
    localparam int IS   = INTEG_W + FRAC_BITS + 1;
    localparam longint unsigned VMUL_L =
        ((64'd1 << VS) + 64'(VEL_PERIOD) - 64'd1) / 64'(VEL_PERIOD);
    localparam logic [VS:0] VMUL = (VS + 1)'(VMUL_L);
    localparam logic [SPIKE_W-1:0] SPIKE_MAX = '1;

    logic signed [CW-1:0]      r_coord, n_coord;
    logic signed [CW-1:0]      r_kept, n_kept;
    logic [SPIKE_W-1:0]        r_spike, n_spike;
    logic signed [OW-1:0]      r_offset, n_offset;
    logic signed [OW-1:0]      r_kept_off;
    logic signed [VW-1:0]      r_velocity, n_velocity;
    logic signed [INTEG_W-1:0] r_integral, n_integral;

    logic signed [CW-1:0]      raw_fx, tgt_fx;
    logic signed [CW:0]        diff, avg_sum, avg_adj;
    logic [CW:0]               diff_mag;
    logic [CMPW-1:0]           mag, limit;
    logic                      is_spike;
    logic signed [CW-1:0]      avg;
    logic signed [IS-1:0]      isum, iq;
    logic                      iround;
    logic signed [VW-1:0]      vdiff;
    logic [VW-1:0]             vmag, vq;
    logic [VW+VS:0]            vprod;

    assign raw_fx = $signed({i_raw, {FRAC_BITS{1'b0}}});
    assign tgt_fx = $signed({i_target, {FRAC_BITS{1'b0}}});

    // Spike test against the last kept coordinate.
    assign diff     = (CW + 1)'(raw_fx) - (CW + 1)'(r_kept);
    assign diff_mag = diff[CW] ? (CW + 1)'(-diff) : (CW + 1)'(diff);
    assign mag      = CMPW'(diff_mag[CW:FRAC_BITS]);
    assign limit    = CMPW'(i_max_step) * CMPW'(r_spike);
    assign is_spike = mag > limit;

    // Average with the kept coordinate, rounded toward zero.
    assign avg_sum = (CW + 1)'(raw_fx) + (CW + 1)'(r_kept);
    assign avg_adj = avg_sum + $signed({{CW{1'b0}}, avg_sum[CW]});
    assign avg     = avg_adj[CW:1];

    always_comb begin
        n_coord = r_coord;
        n_kept  = r_kept;
        n_spike = r_spike;
        if (i_ctl.zero) begin
            n_coord = '0;
        end else if (i_ctl.acquire) begin
            n_coord = raw_fx;
            n_kept  = raw_fx;
        end else if (i_ctl.filter) begin
            if (is_spike) begin
                n_coord = r_kept;
                n_spike = (r_spike == SPIKE_MAX) ? r_spike : r_spike + 1'b1;
            end else begin
                n_coord = avg;
                n_kept  = avg;
                n_spike = SPIKE_W'(1);
            end
        end
    end

    assign n_offset = OW'(n_coord) - OW'(tgt_fx);

    // Integral in whole units; the fractional part of the sum is dropped
    // toward zero, then the sum saturates to 32 bits.
    assign isum   = (IS'(r_integral) <<< FRAC_BITS) + IS'(n_offset);
    assign iround = isum[IS-1] && (|isum[FRAC_BITS-1:0]);
    assign iq     = (isum >>> FRAC_BITS) + $signed({{(IS-1){1'b0}}, iround});

    always_comb begin
        if ((&iq[IS-1:INTEG_W-1]) || !(|iq[IS-1:INTEG_W-1])) begin
            n_integral = iq[INTEG_W-1:0];
        end else if (iq[IS-1]) begin
            n_integral = {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            n_integral = {1'b0, {(INTEG_W-1){1'b1}}};
        end
    end

    // Velocity: offset change over the period, divided by the period with a
    // reciprocal multiply on the magnitude (exact for this operand width).
    assign vdiff      = VW'(n_offset) - VW'(r_kept_off);
    assign vmag       = vdiff[VW-1] ? VW'(-vdiff) : VW'(vdiff);
    assign vprod      = (VW + VS + 1)'(vmag) * (VW + VS + 1)'(VMUL);
    assign vq         = vprod[VS +: VW];
    assign n_velocity = vdiff[VW-1] ? -$signed(vq) : $signed(vq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord    <= '0;
            r_kept     <= '0;
            r_spike    <= SPIKE_W'(1);
            r_offset   <= '0;
            r_kept_off <= '0;
            r_velocity <= '0;
            r_integral <= '0;
        end else if (i_ctl.step) begin
            r_coord <= n_coord;
            r_kept  <= n_kept;
            r_spike <= n_spike;
            if (i_ctl.zero) begin
                r_integral <= '0;
            end else if (i_ctl.track) begin
                r_integral <= n_integral;
            end
            if (i_ctl.track) begin
                r_offset <= n_offset;
                if (i_ctl.vel_upd) begin
                    r_velocity <= n_velocity;
                    r_kept_off <= n_offset;
                end
            end
        end
    end

    assign o_coord    = r_coord;
    assign o_offset   = r_offset;
    assign o_velocity = r_velocity;
    assign o_integral = r_integral;

endmodule

`default_nettype wire

// ===== design/pbf_pid.sv =====
// ----------------------------------------------------------------------------
// pbf_pid
// One PID output: registered gain products, then sum, truncation toward zero
// and saturation to the tilt limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbf_pid
    import pbf_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8,
    parameter int TILT_LIMIT  = 910
) (
    input  wire                                    i_clk,
    input  wire                                    i_load,
    input  wire  [GAIN_W-1:0]                      i_gain_p,
    input  wire  [GAIN_W-1:0]                      i_gain_i,
    input  wire  [GAIN_W-1:0]                      i_gain_d,
    input  wire signed [SAMPLE_BITS+FRAC_BITS:0]   i_offset,
    input  wire signed [SAMPLE_BITS+FRAC_BITS+1:0] i_velocity,
    input  wire signed [INTEG_W-1:0]               i_integral,
    output logic signed [PID_W-1:0]                o_pid
);

    localparam int OW  = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int VW  = OW + 1;
    localparam int PW  = GAIN_W + 1 + OW;
    localparam int DW  = GAIN_W + 1 + VW;
    localparam int IW  = GAIN_W + 1 + INTEG_W;
    localparam int ICW = ITERM_LIM_EXP + 2;
    localparam int TA  = ICW + FRAC_BITS;
    localparam int TW  = ((TA > DW) ? TA : DW) + 2;
    localparam int SH  = GAIN_FRAC + FRAC_BITS;

    localparam logic signed [IW-1:0] ILIM_HI = IW'(64'sd1 <<< ITERM_LIM_EXP);
    localparam logic signed [IW-1:0] ILIM_LO = -ILIM_HI;
    localparam logic signed [TW-1:0] LIM_HI  = TW'(TILT_LIMIT);
    localparam logic signed [TW-1:0] LIM_LO  = -LIM_HI;

    logic signed [PW-1:0]  r_p;
    logic signed [DW-1:0]  r_d;
    logic signed [IW-1:0]  r_i;

    logic signed [ICW-1:0] i_clamped;
    logic signed [TW-1:0]  total, tq, tsat;
    logic                  tround;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p <= $signed({1'b0, i_gain_p}) * i_offset;
            r_d <= $signed({1'b0, i_gain_d}) * i_velocity;
            r_i <= $signed({1'b0, i_gain_i}) * i_integral;
        end
    end

    // The integral term is bounded before the sum so a huge term still
    // saturates the output in its own direction.
    always_comb begin
        if (r_i > ILIM_HI) begin
            i_clamped = ICW'(ILIM_HI);
        end else if (r_i < ILIM_LO) begin
            i_clamped = ICW'(ILIM_LO);
        end else begin
            i_clamped = ICW'(r_i);
        end
    end

    assign total  = TW'(r_p) + TW'(r_d) + (TW'(i_clamped) <<< FRAC_BITS);
    assign tround = total[TW-1] && (|total[SH-1:0]);
    assign tq     = (total >>> SH) + $signed({{(TW-1){1'b0}}, tround});

    always_comb begin
        if (tq > LIM_HI) begin
            tsat = LIM_HI;
        end else if (tq < LIM_LO) begin
            tsat = LIM_LO;
        end else begin
            tsat = tq;
        end
    end

    assign o_pid = PID_W'(tsat);

endmodule

`default_nettype wire

// ===== design/plate_ball_filter_pid.sv =====
// ----------------------------------------------------------------------------
// plate_ball_filter_pid
// Two-axis ball-on-plate controller: ball loss detection, spike filter and
// PID per axis, producing saturated tilt commands and the filtered position.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one control tick and yields exactly one
// request on the master stream. The block takes one tick per clock cycle when
// the master side keeps up. A tick passes through the pipeline in order: the
// state update of the filter, integral and velocity at the accept edge, a
// register stage holding the three gain products per axis, and the output
// register after the sum and saturation. s_axis_tready follows m_axis_tready
// through the three pipeline valid flags, so it drops only when every stage
// holds a result. Gains, loss cutoff and step limit are to be written on the
// plain write port by the user only while no tick is in flight; the block does
// not enforce this. There is no read-back and no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module plate_ball_filter_pid
    import pbf_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8,
    parameter int VEL_PERIOD  = 3,
    parameter int TILT_LIMIT  = 910
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,

    // Slave stream, tdata fields from the lowest bit up:
    // raw_x, raw_y, target_x, target_y (each SAMPLE_BITS, signed), zero pad.
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [((4*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,

    // Master stream, tdata fields from the lowest bit up:
    // tilt_x (11, signed), tilt_y (11, signed), pos_x (SAMPLE_BITS, signed),
    // pos_y (SAMPLE_BITS, signed), ball_present (1), zero pad.
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [((2*TILT_W+2*SAMPLE_BITS+1+7)/8)*8-1:0] m_axis_tdata,

    // Configuration write port.
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int S      = SAMPLE_BITS;
    localparam int CW     = SAMPLE_BITS + FRAC_BITS;
    localparam int OUT_W  = 2 * TILT_W + 2 * SAMPLE_BITS + 1;
    localparam int OUT_BW = ((OUT_W + 7) / 8) * 8;

    // Configuration registers.
    logic [GAIN_W-1:0] r_gain_p_x, r_gain_i_x, r_gain_d_x;
    logic [GAIN_W-1:0] r_gain_p_y, r_gain_i_y, r_gain_d_y;
    logic [LOSS_W-1:0] r_cutoff;
    logic [STEP_W-1:0] r_max_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p_x <= GAIN_P_RST;
            r_gain_i_x <= GAIN_I_RST;
            r_gain_d_x <= GAIN_D_RST;
            r_gain_p_y <= GAIN_P_RST;
            r_gain_i_y <= GAIN_I_RST;
            r_gain_d_y <= GAIN_D_RST;
            r_cutoff   <= LOSS_CUTOFF_RST;
            r_max_step <= MAX_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIN_P_X:    r_gain_p_x <= i_cfg_data;
                REG_GAIN_I_X:    r_gain_i_x <= i_cfg_data;
                REG_GAIN_D_X:    r_gain_d_x <= i_cfg_data;
                REG_GAIN_P_Y:    r_gain_p_y <= i_cfg_data;
                REG_GAIN_I_Y:    r_gain_i_y <= i_cfg_data;
                REG_GAIN_D_Y:    r_gain_d_y <= i_cfg_data;
                REG_LOSS_CUTOFF: r_cutoff   <= i_cfg_data[LOSS_W-1:0];
                REG_MAX_STEP:    r_max_step <= i_cfg_data[STEP_W-1:0];
                default:         r_max_step <= r_max_step;
            endcase
        end
    end

    // Pipeline control. Stage A is the state registers themselves, valid in
    // the cycle after a tick is accepted; stage B holds the gain products;
    // stage C is the output register.
    logic r_a_valid, r_b_valid, r_c_valid;
    logic c_load, b_free, a_free, accept;

    assign c_load        = !r_c_valid || m_axis_tready;
    assign b_free        = !r_b_valid || c_load;
    assign a_free        = !r_a_valid || b_free;
    assign s_axis_tready = a_free;
    assign accept        = s_axis_tvalid && a_free;

    // Input fields.
    logic [S-1:0] raw_x, raw_y, tgt_x, tgt_y;

    assign raw_x = s_axis_tdata[S-1:0];
    assign raw_y = s_axis_tdata[2*S-1:S];
    assign tgt_x = s_axis_tdata[3*S-1:2*S];
    assign tgt_y = s_axis_tdata[4*S-1:3*S];

    // Ball loss and presence tracking. The loss counter is never cleared by
    // good samples; once it passes the cutoff the ball is declared absent.
    logic               r_present;
    logic [LOSS_W-1:0]  r_loss;
    logic [PHASE_W-1:0] r_phase;
    logic               loss, cut, present_new;
    logic [LOSS_W:0]    loss_next;
    t_axis_ctl          ctl;

    assign loss = ($signed(raw_x) < $signed(S'(LOSS_X_LOW)))
               || ($signed(raw_y) > $signed(S'(LOSS_Y_HIGH)));
    assign loss_next = {1'b0, r_loss} + 1'b1;
    assign cut       = loss_next > {1'b0, r_cutoff};

    always_comb begin
        if (loss) begin
            present_new = r_present && !cut;
        end else begin
            present_new = 1'b1;
        end
    end

    assign ctl.step    = accept;
    assign ctl.zero    = loss && cut;
    assign ctl.acquire = !loss && !r_present;
    assign ctl.filter  = !loss && r_present;
    assign ctl.track   = present_new;
    assign ctl.vel_upd = r_phase >= PHASE_W'(VEL_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b1;
            r_loss    <= '0;
            r_phase   <= '0;
        end else if (accept) begin
            r_present <= present_new;
            if (loss) begin
                r_loss <= cut ? '0 : loss_next[LOSS_W-1:0];
            end
            if (present_new) begin
                r_phase <= ctl.vel_upd ? '0 : r_phase + 1'b1;
            end
        end
    end

    // Axis state: x uses the x sample and setpoint, y likewise.
    logic signed [CW-1:0]      coord_x, coord_y;
    logic signed [CW:0]        offset_x, offset_y;
    logic signed [CW+1:0]      velocity_x, velocity_y;
    logic signed [INTEG_W-1:0] integral_x, integral_y;

    pbf_axis #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .VEL_PERIOD  (VEL_PERIOD)
    ) u_axis_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_raw      (raw_x),
        .i_target   (tgt_x),
        .i_max_step (r_max_step),
        .o_coord    (coord_x),
        .o_offset   (offset_x),
        .o_velocity (velocity_x),
        .o_integral (integral_x)
    );

    pbf_axis #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .VEL_PERIOD  (VEL_PERIOD)
    ) u_axis_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_raw      (raw_y),
        .i_target   (tgt_y),
        .i_max_step (r_max_step),
        .o_coord    (coord_y),
        .o_offset   (offset_y),
        .o_velocity (velocity_y),
        .o_integral (integral_y)
    );

    // PID per axis. The y axis drives tilt_x and the x axis drives tilt_y,
    // the latter negated.
    logic signed [PID_W-1:0] pid_x, pid_y;

    pbf_pid #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .TILT_LIMIT  (TILT_LIMIT)
    ) u_pid_x (
        .i_clk      (i_clk),
        .i_load     (b_free),
        .i_gain_p   (r_gain_p_x),
        .i_gain_i   (r_gain_i_x),
        .i_gain_d   (r_gain_d_x),
        .i_offset   (offset_x),
        .i_velocity (velocity_x),
        .i_integral (integral_x),
        .o_pid      (pid_x)
    );

    pbf_pid #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .TILT_LIMIT  (TILT_LIMIT)
    ) u_pid_y (
        .i_clk      (i_clk),
        .i_load     (b_free),
        .i_gain_p   (r_gain_p_y),
        .i_gain_i   (r_gain_i_y),
        .i_gain_d   (r_gain_d_y),
        .i_offset   (offset_y),
        .i_velocity (velocity_y),
        .i_integral (integral_y),
        .o_pid      (pid_y)
    );

    // Position rounded toward zero to whole units, captured with the
    // products in stage B.
    logic signed [CW-1:0] pos_adj_x, pos_adj_y;
    logic [S-1:0]         r_b_pos_x, r_b_pos_y;
    logic                 r_b_present;

    assign pos_adj_x = coord_x + (coord_x[CW-1] ? CW'({FRAC_BITS{1'b1}}) : '0);
    assign pos_adj_y = coord_y + (coord_y[CW-1] ? CW'({FRAC_BITS{1'b1}}) : '0);

    always_ff @(posedge i_clk) begin
        if (b_free) begin
            r_b_pos_x   <= pos_adj_x[CW-1:FRAC_BITS];
            r_b_pos_y   <= pos_adj_y[CW-1:FRAC_BITS];
            r_b_present <= r_present;
        end
    end

    // Output register.
    logic signed [PID_W-1:0] neg_pid_x;
    logic [TILT_W-1:0]       r_tilt_x, r_tilt_y;
    logic [S-1:0]            r_pos_x, r_pos_y;
    logic                    r_c_present;

    assign neg_pid_x = -pid_x;

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_tilt_x    <= pid_y[TILT_W-1:0];
            r_tilt_y    <= neg_pid_x[TILT_W-1:0];
            r_pos_x     <= r_b_pos_x;
            r_pos_y     <= r_b_pos_y;
            r_c_present <= r_b_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= accept;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (c_load) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    assign m_axis_tvalid = r_c_valid;
    assign m_axis_tdata  = {{(OUT_BW - OUT_W){1'b0}}, r_c_present, r_pos_y, r_pos_x,
                            r_tilt_y, r_tilt_x};

    // Checks.
`include "plate_ball_filter_pid_assert.svh"

    `PBF_ASSERT_NOW(a_phase_range, i_clk, i_rst_n, 1'b1, r_phase <= PHASE_W'(VEL_PERIOD))
    `PBF_ASSERT_NEXT(a_accept_fills_a, i_clk, i_rst_n, accept, r_a_valid)
    `PBF_ASSERT_NEXT(a_stage_b_holds, i_clk, i_rst_n, r_b_valid && !c_load, r_b_valid)
    `PBF_ASSERT_NEXT(a_reacquire, i_clk, i_rst_n, accept && !loss && !r_present, r_present)
    `PBF_ASSERT_NEXT(a_loss_cutoff, i_clk, i_rst_n, accept && loss && cut,
                     !r_present && (r_loss == '0))

endmodule

`default_nettype wire

// ===== tb/plate_ball_filter_pid_tb.sv =====
// ----------------------------------------------------------------------------
// plate_ball_filter_pid_tb
// Self-checking bench for the two-axis plate ball controller. A behavioral
// copy of the loss detector, spike filter and PID predicts every tilt and
// position result, and a monitor compares each output request against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plate_ball_filter_pid_tb
    import pbf_pkg::*;
();

    // Fixed-point and control constants of the block as instantiated.
    localparam longint ONE         = 256;      // one unit at 8 fractional bits
    localparam longint VEL_DIV     = 3;
    localparam int     VEL_EVERY   = 3;        // phase count before an update
    localparam longint TILT_MAX    = 910;
    localparam int     SPIKE_SAT   = 1023;
    localparam int     RAW_X_FLOOR = -120;     // x below this means ball lost
    localparam int     RAW_Y_CEIL  = 100;      // y above this means ball lost
    localparam longint INT32_HI    = 64'sd2147483647;
    localparam longint INT32_LO    = -64'sd2147483648;

    localparam int SETTLE_CYCLES = 6;          // pipeline is three deep
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_LIMIT   = 5000;

    // One control tick, laid out exactly as on s_axis_tdata (raw_x lowest).
    typedef struct packed {
        logic signed [11:0] tgt_y;
        logic signed [11:0] tgt_x;
        logic signed [11:0] raw_y;
        logic signed [11:0] raw_x;
    } t_tick;

    // One controller result, laid out as the low 47 bits of m_axis_tdata.
    typedef struct packed {
        logic               present;
        logic signed [11:0] pos_y;
        logic signed [11:0] pos_x;
        logic signed [10:0] tilt_y;
        logic signed [10:0] tilt_x;
    } t_tilt_result;

    typedef enum {RCV_FREE, RCV_PATCHY, RCV_CHOKED} t_rcv_mode;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata  = '0;   // raw_x, raw_y, target_x, target_y
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [47:0]           m_axis_tdata;         // tilt_x, tilt_y, pos_x, pos_y, ball_present, pad
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    always #5 i_clk = ~i_clk;

    plate_ball_filter_pid uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Controller state as the bench expects it. Index 0 is x, index 1 is y.
    // ------------------------------------------------------------------------
    logic [23:0] gain_cfg [6];
    logic [7:0]  cutoff_cfg;
    logic [7:0]  step_cfg;

    bit     ball_on;
    int     loss_ticks;
    int     spike_run [2];
    longint coord_q [2];
    longint kept_q [2];
    longint off_q [2];
    longint kept_off_q [2];
    longint vel_q [2];
    longint integ_q [2];
    int     vel_phase;

    t_tilt_result pending_cmds [$];   // expected results, oldest first

    int fail_count      = 0;
    int ticks_sent      = 0;
    int loss_sent       = 0;
    int settings_loaded = 0;
    int results_checked = 0;
    int cycle_count     = 0;
    int burst_left      = 0;

    function automatic void reset_predictor();
        gain_cfg[0] = GAIN_P_RST; gain_cfg[1] = GAIN_I_RST; gain_cfg[2] = GAIN_D_RST;
        gain_cfg[3] = GAIN_P_RST; gain_cfg[4] = GAIN_I_RST; gain_cfg[5] = GAIN_D_RST;
        cutoff_cfg = LOSS_CUTOFF_RST;
        step_cfg   = MAX_STEP_RST;
        ball_on    = 1'b1;
        loss_ticks = 0;
        vel_phase  = 0;
        for (int i = 0; i < 2; i++) begin
            spike_run[i] = 1;
            coord_q[i] = 0; kept_q[i] = 0;
            off_q[i] = 0; kept_off_q[i] = 0;
            vel_q[i] = 0; integ_q[i] = 0;
        end
    endfunction

    // PID of one axis. The integral term is bounded to +-2^40 before the sum
    // so a huge integral still pushes the tilt the right way.
    function automatic longint axis_pid(input int a, input logic [23:0] gp, gi, gd);
        longint lim, p, d, it, total, r;
        lim   = longint'(1) << 40;
        p     = longint'(gp) * off_q[a];
        d     = longint'(gd) * vel_q[a];
        it    = longint'(gi) * integ_q[a];
        if (it > lim) it = lim;
        if (it < -lim) it = -lim;
        total = p + d + it * ONE;
        r     = total / (longint'(1) << 24);
        if (r > TILT_MAX) r = TILT_MAX;
        if (r < -TILT_MAX) r = -TILT_MAX;
        return r;
    endfunction

    // Advances the expected state by one tick and returns the result it gives.
    function automatic t_tilt_result control_tick(input t_tick t);
        longint rawv [2];
        longint tgtv [2];
        longint diff, mag, s, tx, ty, px, py;
        t_tilt_result res;
        rawv[0] = longint'(t.raw_x); rawv[1] = longint'(t.raw_y);
        tgtv[0] = longint'(t.tgt_x); tgtv[1] = longint'(t.tgt_y);

        if (rawv[0] < RAW_X_FLOOR || rawv[1] > RAW_Y_CEIL) begin
            // Good samples leave the loss counter alone; only a cutoff clears it.
            loss_sent++;
            if (loss_ticks + 1 > int'(cutoff_cfg)) begin
                coord_q[0] = 0; coord_q[1] = 0;
                integ_q[0] = 0; integ_q[1] = 0;
                loss_ticks = 0;
                ball_on    = 1'b0;
            end else begin
                loss_ticks++;
            end
        end else if (ball_on) begin
            for (int i = 0; i < 2; i++) begin
                diff = rawv[i] * ONE - kept_q[i];
                mag  = (diff < 0 ? -diff : diff) / ONE;
                if (mag > longint'(step_cfg) * longint'(spike_run[i])) begin
                    if (spike_run[i] < SPIKE_SAT) spike_run[i]++;
                    coord_q[i] = kept_q[i];
                end else begin
                    coord_q[i]   = (rawv[i] * ONE + kept_q[i]) / 2;
                    kept_q[i]    = coord_q[i];
                    spike_run[i] = 1;
                end
            end
        end else begin
            // Reacquire: jump straight to the sample, spike runs untouched.
            ball_on = 1'b1;
            for (int i = 0; i < 2; i++) begin
                coord_q[i] = rawv[i] * ONE;
                kept_q[i]  = coord_q[i];
            end
        end

        if (ball_on) begin
            for (int i = 0; i < 2; i++) begin
                off_q[i] = coord_q[i] - tgtv[i] * ONE;
                s = (integ_q[i] * ONE + off_q[i]) / ONE;
                if (s > INT32_HI) s = INT32_HI;
                if (s < INT32_LO) s = INT32_LO;
                integ_q[i] = s;
            end
            if (vel_phase >= VEL_EVERY) begin
                for (int i = 0; i < 2; i++) begin
                    vel_q[i]      = (off_q[i] - kept_off_q[i]) / VEL_DIV;
                    kept_off_q[i] = off_q[i];
                end
                vel_phase = 0;
            end else begin
                vel_phase = (vel_phase + 1) & 7;
            end
        end

        // The y axis drives tilt_x; the x axis drives tilt_y, negated.
        tx = axis_pid(1, gain_cfg[3], gain_cfg[4], gain_cfg[5]);
        ty = -axis_pid(0, gain_cfg[0], gain_cfg[1], gain_cfg[2]);
        px = coord_q[0] / ONE;
        py = coord_q[1] / ONE;
        res.tilt_x  = tx[10:0];
        res.tilt_y  = ty[10:0];
        res.pos_x   = px[11:0];
        res.pos_y   = py[11:0];
        res.present = ball_on;
        return res;
    endfunction

    function automatic t_tick tick_of(input int rx, ry, gx, gy);
        t_tick t;
        t.raw_x = rx[11:0];
        t.raw_y = ry[11:0];
        t.tgt_x = gx[11:0];
        t.tgt_y = gy[11:0];
        return t;
    endfunction

    function automatic int clip(input int v, lo, hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. Requests go out in bursts of random length; between bursts
    // tvalid drops for a random gap, or stays up when the gap comes out zero.
    // tvalid is only lowered when a gap really follows, so it never sees a low
    // and a high assignment in the same time step.
    // ------------------------------------------------------------------------
    task automatic send_tick(input t_tick t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        pending_cmds.push_back(control_tick(t));
        ticks_sent++;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Holds the sender until every expected result is back or the drain limit runs
    // out, then lets the pipeline settle. Register writes only ever follow this.
    task automatic wait_for_results();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (idx <= REG_GAIN_D_Y)
            gain_cfg[idx] = data;
        else if (idx == REG_LOSS_CUTOFF)
            cutoff_cfg = data[7:0];
        else
            step_cfg = data[7:0];
    endtask

    task automatic load_settings(input logic [23:0] px, ix, dx, py, iy, dy,
                                 input logic [7:0] cut, stp);
        wait_for_results();
        write_reg(REG_GAIN_P_X, px);
        write_reg(REG_GAIN_I_X, ix);
        write_reg(REG_GAIN_D_X, dx);
        write_reg(REG_GAIN_P_Y, py);
        write_reg(REG_GAIN_I_Y, iy);
        write_reg(REG_GAIN_D_Y, dy);
        write_reg(REG_LOSS_CUTOFF, {16'd0, cut});
        write_reg(REG_MAX_STEP, {16'd0, stp});
        settings_loaded++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side. tready follows one of three moods, each kept for a
    // random stretch: always ready, mostly ready, or mostly stalled.
    // ------------------------------------------------------------------------
    t_rcv_mode rcv_mode = RCV_FREE;
    int        rcv_left = 0;

    always @(posedge i_clk) begin
        if (rcv_left == 0) begin
            rcv_mode = t_rcv_mode'($urandom_range(0, 2));
            rcv_left = $urandom_range(16, 160);
        end else begin
            rcv_left--;
        end
        case (rcv_mode)
            RCV_FREE:   m_axis_tready <= 1'b1;
            RCV_PATCHY: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default:    m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Result monitor. Values are read at the rising edge, so they are the
    // ones the handshake saw.
    // ------------------------------------------------------------------------
    t_tilt_result want_res;
    t_tilt_result got_res;

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_cmds.size() == 0) begin
                $error("result request with no tick outstanding: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want_res = pending_cmds.pop_front();
                got_res  = m_axis_tdata[46:0];
                check_field("tilt_x", want_res.tilt_x, got_res.tilt_x);
                check_field("tilt_y", want_res.tilt_y, got_res.tilt_y);
                check_field("pos_x", want_res.pos_x, got_res.pos_x);
                check_field("pos_y", want_res.pos_y, got_res.pos_y);
                check_field("ball_present", want_res.present, got_res.present);
                results_checked++;
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("plate_ball_filter_pid_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset gains: field extremes, window edges of the loss test, and a spike
    // that keeps repeating while the spike count grows.
    task automatic test_field_extremes();
        send_tick(tick_of(0, 0, 0, 0));
        send_tick(tick_of(2, -3, 0, 0));
        send_tick(tick_of(4, 4, -5, 7));
        send_tick(tick_of(100, -100, 0, 0));
        send_tick(tick_of(100, -100, 0, 0));
        send_tick(tick_of(100, -100, 0, 0));
        send_tick(tick_of(2047, 100, 2047, 2047));
        send_tick(tick_of(-120, -2048, -2048, -2048));
        send_tick(tick_of(-121, 0, 0, 0));
        send_tick(tick_of(0, 101, 0, 0));
        send_tick(tick_of(-2048, 2047, 2047, -2048));
        send_tick(tick_of(2047, -2048, -2048, 2047));
        send_tick(tick_of(1, 1, 1, 1));
        send_tick(tick_of(-1, -1, -1, -1));
        send_tick(tick_of(0, 0, 2047, -2048));
        send_tick(tick_of(0, 0, -2048, 2047));
    endtask

    // Losing and finding the ball. With cutoff 0 the first bad sample drops
    // it; with cutoff 3 good samples in between must not reset the count.
    task automatic test_ball_loss();
        load_settings(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, GAIN_P_RST, GAIN_I_RST,
                      GAIN_D_RST, 8'd0, MAX_STEP_RST);
        send_tick(tick_of(-200, 0, 5, 5));
        send_tick(tick_of(-200, 300, 5, 5));
        send_tick(tick_of(50, -30, 10, 10));
        send_tick(tick_of(52, -28, 10, 10));
        load_settings(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, GAIN_P_RST, GAIN_I_RST,
                      GAIN_D_RST, 8'd3, MAX_STEP_RST);
        send_tick(tick_of(0, 500, 0, 0));
        send_tick(tick_of(53, -27, 0, 0));
        send_tick(tick_of(-500, 0, 0, 0));
        send_tick(tick_of(54, -26, 0, 0));
        send_tick(tick_of(-1000, -1000, 0, 0));
        send_tick(tick_of(0, 2000, 0, 0));
        send_tick(tick_of(-60, -60, 0, 0));
        send_tick(tick_of(-58, -61, 0, 0));
    endtask

    // Step limit zero: only a sample within one unit of the kept position is
    // taken; anything farther is a spike however long the run grows.
    task automatic test_zero_step();
        load_settings(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, GAIN_P_RST, GAIN_I_RST,
                      GAIN_D_RST, LOSS_CUTOFF_RST, 8'd0);
        for (int n = 0; n < 3; n++) begin
            send_tick(tick_of(int'(kept_q[0] / ONE), int'(kept_q[1] / ONE), 0, 0));
            send_tick(tick_of(int'(kept_q[0] / ONE) + 1, int'(kept_q[1] / ONE) - 1, 0, 0));
            send_tick(tick_of(int'(kept_q[0] / ONE) + 7, int'(kept_q[1] / ONE), 3, -3));
        end
    endtask

    // Cutoff 255: the loss count is first brought to zero, then the ball must
    // survive 255 bad samples and drop on the 256th.
    task automatic test_full_cutoff();
        t_tick t;
        load_settings(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, GAIN_P_RST, GAIN_I_RST,
                      GAIN_D_RST, 8'd0, MAX_STEP_RST);
        send_tick(tick_of(-2048, 0, 0, 0));
        load_settings(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, GAIN_P_RST, GAIN_I_RST,
                      GAIN_D_RST, 8'd255, MAX_STEP_RST);
        send_tick(tick_of(10, 10, 0, 0));
        for (int n = 0; n < 256; n++) begin
            t = 48'({$urandom(), $urandom()});
            t.raw_x = 12'(int'($urandom_range(0, 1927)) - 2048);
            send_tick(t);
        end
        send_tick(tick_of(20, -20, 0, 0));
        send_tick(tick_of(21, -19, 0, 0));
    endtask

    // Maximum integral gain with the offset pinned at its largest: the
    // integral term passes its bound in both directions.
    task automatic test_integral_bound();
        load_settings(24'd0, 24'hFFFFFF, 24'd0, 24'd0, 24'hFFFFFF, 24'd0,
                      LOSS_CUTOFF_RST, 8'd255);
        for (int n = 0; n < 32; n++)
            send_tick(tick_of(2047, 100, -2048, -2048));
        for (int n = 0; n < 80; n++)
            send_tick(tick_of(-120, -2048, 2047, 2047));
    endtask

    // Random phases under six register settings, the extremes among them.
    // Most ticks follow a ball that moves in small random steps near a setpoint;
    // the rest are spikes, runs of lost samples and raw noise.
    task automatic test_random_settings();
        t_tick t;
        logic [47:0] noise;
        int wx, wy, sel, lost_run, sp;
        lost_run = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_settings(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, GAIN_P_RST,
                                 GAIN_I_RST, GAIN_D_RST, LOSS_CUTOFF_RST, MAX_STEP_RST);
                1: load_settings(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 8'd0, 8'd0);
                2: load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                 24'hFFFFFF, 24'hFFFFFF, 8'd255, 8'd255);
                default: load_settings(24'($urandom_range(0, 24'h040000)),
                                       24'($urandom_range(0, 24'h001000)),
                                       24'($urandom_range(0, 24'hFFFFFF)),
                                       24'($urandom_range(0, 24'h040000)),
                                       24'($urandom_range(0, 24'h001000)),
                                       24'($urandom_range(0, 24'hFFFFFF)),
                                       8'($urandom_range(0, 60)),
                                       8'($urandom_range(0, 12)));
            endcase
            wx = clip(int'(kept_q[0] / ONE), RAW_X_FLOOR, 2047);
            wy = clip(int'(kept_q[1] / ONE), -2048, RAW_Y_CEIL);
            for (int n = 0; n < 130; n++) begin
                sel = $urandom_range(0, 99);
                if (lost_run > 0 || (sel >= 72 && sel < 80)) begin
                    if (lost_run > 0)
                        lost_run--;
                    else
                        lost_run = $urandom_range(0, 40);
                    noise = 48'({$urandom(), $urandom()});
                    t = noise;
                    if ($urandom_range(0, 1))
                        t.raw_x = 12'(int'($urandom_range(0, 1927)) - 2048);
                    else
                        t.raw_y = 12'($urandom_range(101, 2047));
                end else if (sel >= 90) begin
                    noise = 48'({$urandom(), $urandom()});
                    t = noise;
                end else begin
                    if (sel < 72) begin
                        sp = $urandom_range(0, 6);
                        wx = clip(wx + int'($urandom_range(0, 2 * sp)) - sp, RAW_X_FLOOR, 2047);
                        wy = clip(wy + int'($urandom_range(0, 2 * sp)) - sp, -2048, RAW_Y_CEIL);
                        t = tick_of(wx, wy, 0, 0);
                    end else begin
                        // A spike: any good-window sample, wherever the ball is.
                        t = tick_of(int'($urandom_range(0, 2167)) + RAW_X_FLOOR,
                                    int'($urandom_range(0, 2148)) - 2048, 0, 0);
                    end
                    if ($urandom_range(0, 19) != 0) begin
                        t.tgt_x = 12'(clip(wx + int'($urandom_range(0, 80)) - 40, -2048, 2047));
                        t.tgt_y = 12'(clip(wy + int'($urandom_range(0, 80)) - 40, -2048, 2047));
                    end else begin
                        t.tgt_x = 12'($urandom());
                        t.tgt_y = 12'($urandom());
                    end
                end
                send_tick(t);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_predictor();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_ball_loss();
        test_zero_step();
        test_full_cutoff();
        test_integral_bound();
        test_random_settings();

        wait_for_results();
        if (pending_cmds.size() != 0) begin
            $error("%0d expected results never arrived", pending_cmds.size());
            fail_count++;
        end

        $display("Ran %0d control ticks (%0d with the ball off the window) under %0d",
                 ticks_sent, loss_sent, settings_loaded);
        $display("register settings; %0d results compared field by field.",
                 results_checked);
        if (fail_count == 0)
            $display("plate_ball_filter_pid_tb OK");
        else
            $display("plate_ball_filter_pid_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/pbf_pkg.sv
design/pbf_axis.sv
design/pbf_pid.sv
design/plate_ball_filter_pid.sv
tb/plate_ball_filter_pid_tb.sv
